// ===== sv/cfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_pkg
// Types and constants shared by the frame decoder front, queue and back.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int unsigned HDR_BYTES   = 5;   // SOF, type, seq hi, seq lo, length
    localparam int unsigned FIXED_BYTES = 7;   // header plus two CRC bytes
    localparam int unsigned CNT_W       = 6;   // width of payload_count

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_LEN = 3'd1,
        ST_BAD_SOF = 3'd2,
        ST_TOO_BIG = 3'd3,
        ST_BAD_CRC = 3'd4
    } t_status;

    // one closed frame, handed from front to back
    typedef struct packed {
        t_status          status;
        logic [7:0]       frame_type;
        logic [15:0]      seq;
        logic [CNT_W-1:0] count;
        logic             bank;
    } t_desc;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    typedef enum logic {
        BK_HEAD,
        BK_DATA
    } t_back_state;

endpackage
`default_nettype wire

// ===== sv/cfd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_in_if / cfd_out_if
// Valid/ready channels for received bytes and for decoded results.
// ----------------------------------------------------------------------------
interface cfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;

    modport source (output valid, output rx_byte, output end_of_frame, input ready);
    modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface cfd_out_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [2:0] status;
    logic [7:0] frame_type;
    logic [15:0] sequence_number;
    logic [5:0] payload_count;
    logic [7:0] payload_byte;
    logic       last_result;

    modport source (output valid, output item_kind, output status, output frame_type,
                    output sequence_number, output payload_count, output payload_byte,
                    output last_result, input ready);
    modport sink   (input valid, input item_kind, input status, input frame_type,
                    input sequence_number, input payload_count, input payload_byte,
                    input last_result, output ready);
endinterface
`default_nettype wire

// ===== sv/cfd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/cfd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_front
// Takes frame bytes, tracks header, CRC and payload bank, and on the closing
// byte classifies the frame and pushes a descriptor to the queue.
// ----------------------------------------------------------------------------
module cfd_front #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    cfd_in_if.sink                     i_rx,
    input  wire logic [7:0]            i_start_byte,
    input  wire cfd_pkg::t_q_stat      i_q_stat,
    output logic                       o_push,
    output cfd_pkg::t_desc             o_desc,
    input  wire logic                  i_release,
    output logic                       o_ram_we,
    output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1):0] o_ram_waddr,
    output logic [7:0]                 o_ram_wdata
);
    import cfd_pkg::*;

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

    function automatic logic [15:0] f_crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic [7:0]  r_cnt,   n_cnt;
    logic [7:0]  r_first, n_first;
    logic [7:0]  r_type,  n_type;
    logic [15:0] r_seq,   n_seq;
    logic [7:0]  r_len,   n_len;
    logic [15:0] r_crc,   r_h0, r_tail;
    logic [15:0] n_tail;
    logic        r_wbank;
    logic [1:0]  r_busy,  n_busy;

    logic        acc;
    logic        eof;
    logic        grow;
    logic [7:0]  b;
    logic [7:0]  off;
    logic [8:0]  len_plus;
    t_status     stat;

    assign b   = i_rx.rx_byte;
    assign eof = i_rx.end_of_frame;

    // both banks waiting for replay, or no room for a descriptor: hold off
    assign i_rx.ready = !i_q_stat.full && (r_busy != 2'd2);
    assign acc        = i_rx.valid && i_rx.ready;

    always_comb begin
        n_cnt   = (r_cnt == 8'hFF) ? 8'hFF : r_cnt + 8'd1;
        n_first = (r_cnt == 8'd0) ? b : r_first;
        n_type  = (r_cnt == 8'd1) ? b : r_type;
        n_seq   = r_seq;
        if (r_cnt == 8'd2) begin
            n_seq = {b, r_seq[7:0]};
        end else if (r_cnt == 8'd3) begin
            n_seq = {r_seq[15:8], b};
        end
        n_len  = (r_cnt == 8'd4) ? b : r_len;
        n_tail = {r_tail[7:0], b};
    end

    assign len_plus = 9'(FIXED_BYTES) + {1'b0, n_len};

    always_comb begin
        if (n_cnt < 8'(FIXED_BYTES)) begin
            stat = ST_BAD_LEN;
        end else if (n_first != i_start_byte) begin
            stat = ST_BAD_SOF;
        end else if (n_len > MAX_B) begin
            stat = ST_TOO_BIG;
        end else if ({1'b0, n_cnt} != len_plus) begin
            stat = ST_BAD_LEN;
        end else if (n_tail != r_h0) begin
            // CRC over all bytes before the two trailing ones
            stat = ST_BAD_CRC;
        end else begin
            stat = ST_OK;
        end
    end

    assign off         = r_cnt - 8'(HDR_BYTES);
    assign o_ram_we    = acc && (r_cnt >= 8'(HDR_BYTES)) && (off < MAX_B);
    assign o_ram_waddr = {r_wbank, off[IDX_W-1:0]};
    assign o_ram_wdata = b;

    assign o_push            = acc && eof;
    assign o_desc.status     = stat;
    assign o_desc.frame_type = (stat == ST_OK) ? n_type : 8'd0;
    assign o_desc.seq        = (stat == ST_OK) ? n_seq : 16'd0;
    assign o_desc.count      = (stat == ST_OK) ? n_len[CNT_W-1:0] : '0;
    assign o_desc.bank       = r_wbank;

    // only good frames with payload hold a bank until replayed
    assign grow = o_push && (stat == ST_OK) && (n_len != 8'd0);

    always_comb begin
        n_busy = r_busy;
        if (grow && !i_release) begin
            n_busy = r_busy + 2'd1;
        end else if (!grow && i_release) begin
            n_busy = r_busy - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 8'd0;
            r_first <= 8'd0;
            r_type  <= 8'd0;
            r_seq   <= 16'd0;
            r_len   <= 8'd0;
            r_crc   <= CRC_INIT;
            r_h0    <= CRC_INIT;
            r_tail  <= 16'd0;
            r_wbank <= 1'b0;
            r_busy  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            if (grow) begin
                r_wbank <= !r_wbank;
            end
            if (acc) begin
                if (eof) begin
                    r_cnt   <= 8'd0;
                    r_first <= 8'd0;
                    r_type  <= 8'd0;
                    r_seq   <= 16'd0;
                    r_len   <= 8'd0;
                    r_crc   <= CRC_INIT;
                    r_h0    <= CRC_INIT;
                    r_tail  <= 16'd0;
                end else begin
                    r_cnt   <= n_cnt;
                    r_first <= n_first;
                    r_type  <= n_type;
                    r_seq   <= n_seq;
                    r_len   <= n_len;
                    r_crc   <= f_crc_byte(r_crc, b);
                    r_h0    <= r_crc;
                    r_tail  <= n_tail;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/cfd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_queue
// Two-entry descriptor queue between frame front and result back.
// ----------------------------------------------------------------------------
module cfd_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire cfd_pkg::t_desc   i_desc,
    input  wire logic             i_pop,
    output cfd_pkg::t_desc        o_desc,
    output cfd_pkg::t_q_stat      o_stat
);
    import cfd_pkg::*;

    t_desc      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_desc       = r_mem[r_rp];
    assign o_stat.valid = (r_cnt != 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/cfd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_back
// Pops frame descriptors, sends the status result and replays the payload
// bank through the output register.
// ----------------------------------------------------------------------------
module cfd_back #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cfd_pkg::t_q_stat      i_q_stat,
    input  wire cfd_pkg::t_desc        i_desc,
    output logic                       o_pop,
    output logic                       o_ram_re,
    output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1):0] o_ram_raddr,
    input  wire logic [7:0]            i_ram_rdata,
    output logic                       o_release,
    cfd_out_if.source                  o_res
);
    import cfd_pkg::*;

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    t_back_state      r_state, n_state;
    logic             r_bank;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] idx_next;

    logic        r_ov;
    logic        r_kind;
    logic [2:0]  r_status;
    logic [7:0]  r_type;
    logic [15:0] r_seq;
    logic [5:0]  r_count;
    logic [7:0]  r_byte;
    logic        r_last;

    logic out_free;
    logic has_data;
    logic last_byte;
    logic ld_head;
    logic ld_data;

    assign out_free  = !r_ov || o_res.ready;
    assign has_data  = (i_desc.status == ST_OK) && (i_desc.count != '0);
    assign idx_next  = r_idx + CNT_W'(1);
    assign last_byte = (idx_next == r_cnt);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_HEAD: begin
                if (i_q_stat.valid && out_free && has_data) begin
                    n_state = BK_DATA;
                end
            end
            BK_DATA: begin
                if (out_free && last_byte) begin
                    n_state = BK_HEAD;
                end
            end
            default: n_state = BK_HEAD;
        endcase
    end

    // outputs
    always_comb begin
        ld_head     = 1'b0;
        ld_data     = 1'b0;
        o_pop       = 1'b0;
        o_ram_re    = 1'b0;
        o_release   = 1'b0;
        o_ram_raddr = {r_bank, idx_next[IDX_W-1:0]};
        case (r_state)
            BK_HEAD: begin
                if (i_q_stat.valid && out_free) begin
                    ld_head     = 1'b1;
                    o_pop       = 1'b1;
                    o_ram_re    = has_data;
                    o_ram_raddr = {i_desc.bank, {IDX_W{1'b0}}};
                end
            end
            BK_DATA: begin
                if (out_free) begin
                    ld_data   = 1'b1;
                    o_release = last_byte;
                    o_ram_re  = !last_byte;  // prefetch the following byte
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_HEAD;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ld_head || ld_data) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_head) begin
            r_bank   <= i_desc.bank;
            r_cnt    <= i_desc.count;
            r_idx    <= '0;
            r_kind   <= 1'b0;
            r_status <= i_desc.status;
            r_type   <= i_desc.frame_type;
            r_seq    <= i_desc.seq;
            r_count  <= i_desc.count;
            r_byte   <= 8'd0;
            r_last   <= !has_data;
        end else if (ld_data) begin
            r_idx    <= idx_next;
            r_kind   <= 1'b1;
            r_status <= ST_OK;
            r_type   <= 8'd0;
            r_seq    <= 16'd0;
            r_count  <= '0;
            r_byte   <= i_ram_rdata;
            r_last   <= last_byte;
        end
    end

    assign o_res.valid           = r_ov;
    assign o_res.item_kind       = r_kind;
    assign o_res.status          = r_status;
    assign o_res.frame_type      = r_type;
    assign o_res.sequence_number = r_seq;
    assign o_res.payload_count   = r_count;
    assign o_res.payload_byte    = r_byte;
    assign o_res.last_result     = r_last;

endmodule
`default_nettype wire

// ===== sv/crc_frame_decoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crc_frame_decoder_core
// Frame parser: SOF, type, sequence, length, payload, CRC-16/MODBUS check.
// ----------------------------------------------------------------------------
// Usage:
//  i_rx carries one frame byte per transfer, end_of_frame set on the last one.
//  o_res carries results: one status/header item per frame, then for a good
//  frame its payload bytes, last_result on the final item of the frame.
//  i_cfg_we/i_cfg_wdata set the expected start byte (0xAA after reset);
//  write it only while the decoder is idle.
// Timing:
//  One byte per cycle is taken on i_rx while ready is high. The status item
//  passes the descriptor queue and output register after the closing byte's
//  transfer; payload bytes follow one per cycle while o_res is ready, paced
//  by the payload RAM read port, while the next frame streams in. Payload RAM
//  holds two banks, so two good frames may await replay; both banks awaiting
//  replay, or a full queue, hold i_rx.ready low until the back end catches up.
// Reset: synchronous, active low; the parser and queue are emptied and no
//  RAM clearing is needed. A stalled o_res simply backs up into the queue.
// ----------------------------------------------------------------------------
module crc_frame_decoder_core #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cfd_in_if.sink    i_rx,
    cfd_out_if.source o_res,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);
    import cfd_pkg::*;

    localparam int IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int RAM_DEPTH = 2 ** (IDX_W + 1);

    logic [7:0]   r_start_byte;
    logic         w_push;
    logic         w_pop;
    logic         w_release;
    t_desc        w_desc_in;
    t_desc        w_desc_out;
    t_q_stat      w_q_stat;
    logic         w_ram_we;
    logic         w_ram_re;
    logic [IDX_W:0] w_ram_waddr;
    logic [IDX_W:0] w_ram_raddr;
    logic [7:0]   w_ram_wdata;
    logic [7:0]   w_ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= 8'hAA;
        end else if (i_cfg_we) begin
            r_start_byte <= i_cfg_wdata;
        end
    end

    cfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_start_byte (r_start_byte),
        .i_q_stat     (w_q_stat),
        .o_push       (w_push),
        .o_desc       (w_desc_in),
        .i_release    (w_release),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata)
    );

    cfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_desc_in),
        .i_pop   (w_pop),
        .o_desc  (w_desc_out),
        .o_stat  (w_q_stat)
    );

    cfd_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    cfd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (w_q_stat),
        .i_desc      (w_desc_out),
        .o_pop       (w_pop),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_release   (w_release),
        .o_res       (o_res)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("descriptor pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_stat.valid)
        else $error("descriptor popped from an empty queue");

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.item_kind && (o_res.status != ST_OK)) |-> o_res.last_result)
        else $error("failed frame status not marked last");

    a_release_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_release |=> (o_res.valid && o_res.item_kind && o_res.last_result))
        else $error("payload bank released before final byte was loaded");

endmodule
`default_nettype wire
